/* rtl/core/gtq_pkg.sv */
// ----------------------------------------------------------------------------
// gtq_pkg
// shared types, codes and widths of the grouped team queue
// ----------------------------------------------------------------------------
package gtq_pkg;

  localparam int unsigned ELEM_W = 10;
  localparam int unsigned TEAM_W = 6;
  localparam int unsigned STAT_W = 2;

  localparam int unsigned ELEMENT_IDS_DEF = 1024;
  localparam int unsigned TEAMS_DEF       = 64;
  localparam int unsigned CAPACITY_DEF    = 1024;

  typedef enum logic [1:0] {
    OP_ASSIGN  = 2'd0,
    OP_ENQUEUE = 2'd1,
    OP_DEQUEUE = 2'd2,
    OP_CLEAR   = 2'd3
  } opcode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic wr;
    logic rd;
    logic clr;
  } mbr_ctl_t;

  typedef struct packed {
    logic pop;
    logic push;
    logic clr;
  } free_ctl_t;

endpackage

/* rtl/core/grouped_team_queue.sv */
// ----------------------------------------------------------------------------
// grouped_team_queue
// team queue: per-team linked lists in a shared node store, ordered by team
// ----------------------------------------------------------------------------
// One word at a time. Enqueue goes through membership read, then team tail
// read, then link write, and stops after the membership read when it is dropped
// on a full store. Dequeue goes through team order read, team head and tail
// read, node read and write back, and stops after the team order read on an
// empty queue. A word that returns a result also waits for the output register
// to be free. After reset and after every clear the membership table is zeroed
// by a pass over all ELEMENT_IDS entries, during which no word is taken.
// Dequeue always returns a word; enqueue returns one only when dropped.
module grouped_team_queue import gtq_pkg::*; #(
  parameter int unsigned ELEMENT_IDS = ELEMENT_IDS_DEF,
  parameter int unsigned TEAMS       = TEAMS_DEF,
  parameter int unsigned CAPACITY    = CAPACITY_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        opcode_i,
  input  logic [ELEM_W-1:0] element_i,
  input  logic [TEAM_W-1:0] team_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ELEM_W-1:0] value_o,
  output logic [STAT_W-1:0] status_o
);

  localparam int unsigned MAW = (ELEMENT_IDS > 1) ? $clog2(ELEMENT_IDS) : 1;
  localparam int unsigned TW  = (TEAMS > 1) ? $clog2(TEAMS) : 1;
  localparam int unsigned NW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_E1   = 3'd1;
  localparam logic [2:0] S_E2   = 3'd2;
  localparam logic [2:0] S_D1   = 3'd3;
  localparam logic [2:0] S_D2   = 3'd4;
  localparam logic [2:0] S_D3   = 3'd5;

  logic [2:0] state_q, state_d;

  logic [ELEM_W-1:0] elem_q;
  logic              elem_ok_q, full_q, same_q;
  logic [TW-1:0]     team_q;
  logic [NW-1:0]     node_q;

  logic [ELEM_W-1:0] val_mem [CAPACITY];
  logic [NW-1:0]     nxt_mem [CAPACITY];
  logic [NW-1:0]     head_mem [TEAMS];
  logic [NW-1:0]     tail_mem [TEAMS];
  logic [TW-1:0]     ord_mem [TEAMS];
  logic [ELEM_W-1:0] val_rd_q;
  logic [NW-1:0]     nxt_rd_q, head_rd_q, tail_rd_q;
  logic [TW-1:0]     ord_rd_q;

  logic [TEAMS-1:0] present_q, present_d;
  logic [TW-1:0]    rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d;
  logic [TW:0]      ord_cnt_q, ord_cnt_d;

  logic              out_valid_q;
  logic [ELEM_W-1:0] value_q;
  logic [STAT_W-1:0] status_q;
  logic              slot_ok, emit;
  logic [ELEM_W-1:0] emit_value;
  status_e           emit_status;

  mbr_ctl_t          mbr_ctl;
  free_ctl_t         free_ctl;
  logic [MAW-1:0]    mbr_addr;
  logic [MAW+ELEM_W-1:0] elem_ext;
  logic [TEAM_W-1:0] mbr_team;
  logic              mbr_busy;
  logic [NW-1:0]     free_node;
  logic              free_empty;

  logic              accept;
  logic              elem_in_range, team_in_range;
  logic [TW+TEAM_W-1:0] mteam_ext;
  logic [TW-1:0]     new_team;

  logic              nv_we, nn_we, hd_we, tl_we, ord_we, ord_re, tm_re, nd_re;
  logic [NW-1:0]     nn_waddr, nn_wdata, hd_wdata, nd_raddr;
  logic [TW-1:0]     tm_raddr;

  assign accept        = in_valid_i && in_ready_o;
  assign in_ready_o    = (state_q == S_IDLE) && !mbr_busy;
  assign elem_ext      = {{MAW{1'b0}}, element_i};
  assign mbr_addr      = elem_ext[MAW-1:0];
  assign elem_in_range = 32'(element_i) < 32'(ELEMENT_IDS);
  assign team_in_range = 32'(team_i) < 32'(TEAMS);
  assign mteam_ext     = {{TW{1'b0}}, mbr_team};
  assign new_team      = (elem_ok_q && 32'(mbr_team) < 32'(TEAMS)) ?
                         mteam_ext[TW-1:0] : '0;
  assign slot_ok       = !out_valid_q || out_ready_i;

  gtq_member #(.ELEMENT_IDS(ELEMENT_IDS)) u_member (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mbr_ctl),
    .wr_addr_i (mbr_addr),
    .wr_team_i (team_i),
    .rd_addr_i (mbr_addr),
    .rd_team_o (mbr_team),
    .busy_o    (mbr_busy)
  );

  gtq_free #(.CAPACITY(CAPACITY)) u_free (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (free_ctl),
    .push_node_i (node_q),
    .pop_node_o  (free_node),
    .empty_o     (free_empty)
  );

  always_comb begin
    state_d     = state_q;
    present_d   = present_q;
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    ord_cnt_d   = ord_cnt_q;
    mbr_ctl     = '0;
    free_ctl    = '0;
    emit        = 1'b0;
    emit_value  = '0;
    emit_status = ST_OK;
    nv_we       = 1'b0;
    nn_we       = 1'b0;
    nn_waddr    = node_q;
    nn_wdata    = '0;
    hd_we       = 1'b0;
    hd_wdata    = node_q;
    tl_we       = 1'b0;
    ord_we      = 1'b0;
    ord_re      = 1'b0;
    tm_re       = 1'b0;
    tm_raddr    = new_team;
    nd_re       = 1'b0;
    nd_raddr    = head_rd_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (opcode_i)
            OP_ASSIGN: begin
              mbr_ctl.wr = elem_in_range && team_in_range;
            end
            OP_ENQUEUE: begin
              mbr_ctl.rd   = 1'b1;
              free_ctl.pop = !free_empty;
              state_d      = S_E1;
            end
            OP_DEQUEUE: begin
              ord_re  = 1'b1;
              state_d = S_D1;
            end
            default: begin
              mbr_ctl.clr  = 1'b1;
              free_ctl.clr = 1'b1;
              present_d    = '0;
              rd_ptr_d     = '0;
              wr_ptr_d     = '0;
              ord_cnt_d    = '0;
            end
          endcase
        end
      end
      S_E1: begin
        if (full_q) begin
          if (slot_ok) begin
            emit        = 1'b1;
            emit_status = ST_FULL;
            state_d     = S_IDLE;
          end
        end else begin
          tm_re   = 1'b1;
          nv_we   = 1'b1;
          nn_we   = 1'b1;
          nn_waddr = free_node;
          state_d = S_E2;
        end
      end
      S_E2: begin
        tl_we = 1'b1;
        if (present_q[team_q]) begin
          nn_we    = 1'b1;
          nn_waddr = tail_rd_q;
          nn_wdata = node_q;
        end else begin
          hd_we              = 1'b1;
          present_d[team_q]  = 1'b1;
          if (ord_cnt_q < (TW+1)'(TEAMS)) begin
            ord_we    = 1'b1;
            wr_ptr_d  = (32'(wr_ptr_q) + 1 >= TEAMS) ? '0 : wr_ptr_q + 1'b1;
            ord_cnt_d = ord_cnt_q + 1'b1;
          end
        end
        state_d = S_IDLE;
      end
      S_D1: begin
        if (ord_cnt_q == '0) begin
          if (slot_ok) begin
            emit        = 1'b1;
            emit_status = ST_EMPTY;
            state_d     = S_IDLE;
          end
        end else begin
          tm_re    = 1'b1;
          tm_raddr = ord_rd_q;
          state_d  = S_D2;
        end
      end
      S_D2: begin
        nd_re   = 1'b1;
        state_d = S_D3;
      end
      S_D3: begin
        if (slot_ok) begin
          emit          = 1'b1;
          emit_value    = val_rd_q;
          free_ctl.push = 1'b1;
          if (same_q) begin
            present_d[team_q] = 1'b0;
            rd_ptr_d  = (32'(rd_ptr_q) + 1 >= TEAMS) ? '0 : rd_ptr_q + 1'b1;
            ord_cnt_d = ord_cnt_q - 1'b1;
          end else begin
            hd_we    = 1'b1;
            hd_wdata = nxt_rd_q;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      present_q   <= '0;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      ord_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      present_q <= present_d;
      rd_ptr_q  <= rd_ptr_d;
      wr_ptr_q  <= wr_ptr_d;
      ord_cnt_q <= ord_cnt_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload and item context
  always_ff @(posedge clk_i) begin
    if (emit) begin
      value_q  <= emit_value;
      status_q <= emit_status;
    end
    if (accept) begin
      elem_q    <= element_i;
      elem_ok_q <= elem_in_range;
      full_q    <= free_empty;
    end
    if (state_q == S_E1) begin
      team_q <= new_team;
      node_q <= free_node;
    end
    if (state_q == S_D1) begin
      team_q <= ord_rd_q;
    end
    if (state_q == S_D2) begin
      node_q <= head_rd_q;
      same_q <= (head_rd_q == tail_rd_q);
    end
  end

  // node store, team pointers and team order
  always_ff @(posedge clk_i) begin
    if (nv_we) begin
      val_mem[free_node] <= elem_q;
    end
    if (nn_we) begin
      nxt_mem[nn_waddr] <= nn_wdata;
    end
    if (nd_re) begin
      val_rd_q <= val_mem[nd_raddr];
      nxt_rd_q <= nxt_mem[nd_raddr];
    end
    if (hd_we) begin
      head_mem[team_q] <= hd_wdata;
    end
    if (tl_we) begin
      tail_mem[team_q] <= node_q;
    end
    if (tm_re) begin
      head_rd_q <= head_mem[tm_raddr];
      tail_rd_q <= tail_mem[tm_raddr];
    end
    if (ord_we) begin
      ord_mem[wr_ptr_q] <= team_q;
    end
    if (ord_re) begin
      ord_rd_q <= ord_mem[rd_ptr_q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

`ifndef SYNTHESIS
  a_ord_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ord_cnt_q <= (TW+1)'(TEAMS))
    else $error("team order count above team count");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == S_IDLE))
    else $error("word taken while busy");

  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && emit_status == ST_EMPTY) |-> (ord_cnt_q == '0))
    else $error("empty reported with teams queued");
`endif

endmodule

/* rtl/core/gtq_member.sv */
// ----------------------------------------------------------------------------
// gtq_member
// membership table: element to team, with a clearing pass after reset and clear
// ----------------------------------------------------------------------------
module gtq_member import gtq_pkg::*; #(
  parameter int unsigned ELEMENT_IDS = ELEMENT_IDS_DEF,
  localparam int unsigned AW = (ELEMENT_IDS > 1) ? $clog2(ELEMENT_IDS) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mbr_ctl_t          ctl_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  logic [TEAM_W-1:0] wr_team_i,
  input  logic [AW-1:0]     rd_addr_i,
  output logic [TEAM_W-1:0] rd_team_o,
  output logic              busy_o
);

  logic [TEAM_W-1:0] team_mem [ELEMENT_IDS];
  logic [TEAM_W-1:0] rd_q;
  logic              busy_q, busy_d;
  logic [AW-1:0]     idx_q, idx_d;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (ctl_i.clr) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (busy_q) begin
      idx_d = idx_q + 1'b1;
      if (idx_q == AW'(ELEMENT_IDS - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      team_mem[idx_q] <= '0;
    end else if (ctl_i.wr) begin
      team_mem[wr_addr_i] <= wr_team_i;
    end
    if (ctl_i.rd) begin
      rd_q <= team_mem[rd_addr_i];
    end
  end

  assign rd_team_o = rd_q;
  assign busy_o    = busy_q;

endmodule

/* rtl/core/gtq_free.sv */
// ----------------------------------------------------------------------------
// gtq_free
// free node stack; positions below the low mark still hold their reset index
// ----------------------------------------------------------------------------
module gtq_free import gtq_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  localparam int unsigned NW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  free_ctl_t     ctl_i,
  input  logic [NW-1:0] push_node_i,
  output logic [NW-1:0] pop_node_o,
  output logic          empty_o
);

  logic [NW-1:0] stack_mem [CAPACITY];
  logic [NW:0]   count_q, count_d, low_q, low_d;
  logic [NW:0]   pop_pos;
  logic [NW-1:0] rdata_q, addr_q;
  logic          fresh_q;

  assign pop_pos = count_q - 1'b1;

  always_comb begin
    count_d = count_q;
    low_d   = low_q;
    if (ctl_i.clr) begin
      count_d = (NW+1)'(CAPACITY);
      low_d   = (NW+1)'(CAPACITY);
    end else if (ctl_i.pop) begin
      count_d = pop_pos;
      if (pop_pos < low_q) begin
        low_d = pop_pos;
      end
    end else if (ctl_i.push && count_q < (NW+1)'(CAPACITY)) begin
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= (NW+1)'(CAPACITY);
      low_q   <= (NW+1)'(CAPACITY);
    end else begin
      count_q <= count_d;
      low_q   <= low_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push && count_q < (NW+1)'(CAPACITY)) begin
      stack_mem[count_q[NW-1:0]] <= push_node_i;
    end
    if (ctl_i.pop) begin
      rdata_q <= stack_mem[pop_pos[NW-1:0]];
      addr_q  <= pop_pos[NW-1:0];
      fresh_q <= (pop_pos < low_q);
    end
  end

  assign pop_node_o = fresh_q ? (NW'(CAPACITY - 1) - addr_q) : rdata_q;
  assign empty_o    = (count_q == '0);

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// checks the grouped team queue against a behavioral team queue: directed
// corner words, a long output hold-off that fills the block and stalls its
// input, then random team scenarios with random idling on output and input
// ----------------------------------------------------------------------------
module testbench;
  import gtq_pkg::*;

  localparam int unsigned NIDS = ELEMENT_IDS_DEF;
  localparam int unsigned NTEAMS = TEAMS_DEF;
  localparam int unsigned CAP = CAPACITY_DEF;

  typedef struct packed {
    opcode_e           op;
    logic [ELEM_W-1:0] elem;
    logic [TEAM_W-1:0] team;
  } word_t;

  typedef struct packed {
    logic [ELEM_W-1:0] value;
    status_e           status;
  } reply_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] opcode_i = '0;
  logic [ELEM_W-1:0] element_i = '0;
  logic [TEAM_W-1:0] team_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [ELEM_W-1:0] value_o;
  logic [STAT_W-1:0] status_o;

  grouped_team_queue u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .opcode_i(opcode_i), .element_i(element_i), .team_i(team_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .value_o(value_o), .status_o(status_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // behavioral team queue
  logic [TEAM_W-1:0] team_of [NIDS];
  logic [ELEM_W-1:0] team_fifo [NTEAMS][$];
  logic [TEAM_W-1:0] team_order [$];
  int unsigned stored;

  word_t  pending_words [$];
  reply_t expected_replies [$];
  int unsigned fails = 0;
  int unsigned n_sent = 0;
  int unsigned n_replies = 0, n_empty = 0, n_full = 0;
  bit no_idle = 1'b0;
  bit hold_out = 1'b0;

  function automatic void clear_queues();
    for (int t = 0; t < NTEAMS; t++) team_fifo[t].delete();
    team_order.delete();
    stored = 0;
  endfunction

  function automatic void add_word(word_t w);
    pending_words.insert(pending_words.size(), w);
    n_sent++;
  endfunction

  function automatic void add_reply(reply_t r);
    expected_replies.insert(expected_replies.size(), r);
  endfunction

  function automatic void predict_word(word_t w);
    reply_t r;
    logic [TEAM_W-1:0] t;
    case (w.op)
      OP_ASSIGN: team_of[w.elem] = w.team;
      OP_ENQUEUE: begin
        t = team_of[w.elem];
        if (stored == CAP) begin
          r.value = '0;
          r.status = ST_FULL;
          add_reply(r);
        end else begin
          stored++;
          if (team_fifo[t].size() == 0) team_order.insert(team_order.size(), t);
          team_fifo[t].insert(team_fifo[t].size(), w.elem);
        end
      end
      OP_DEQUEUE: begin
        if (team_order.size() == 0) begin
          r.value = '0;
          r.status = ST_EMPTY;
        end else begin
          t = team_order[0];
          r.value = team_fifo[t].pop_front();
          r.status = ST_OK;
          stored--;
          if (team_fifo[t].size() == 0) void'(team_order.pop_front());
        end
        add_reply(r);
      end
      default: begin
        foreach (team_of[i]) team_of[i] = '0;
        clear_queues();
      end
    endcase
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_word(word_t'({opcode_i, element_i, team_i}));
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_words.size() > 0 && (no_idle || $urandom_range(99) >= 28)) begin
          word_t w;
          w = pending_words.pop_front();
          in_valid_i <= 1'b1;
          opcode_i <= w.op;
          element_i <= w.elem;
          team_i <= w.team;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        reply_t e;
        n_replies++;
        if (expected_replies.size() == 0) begin
          $error("unexpected reply value=%0d status=%0d", value_o, status_o);
          fails++;
        end else begin
          e = expected_replies.pop_front();
          if (e.status == ST_EMPTY) n_empty++;
          if (e.status == ST_FULL) n_full++;
          if (value_o !== e.value) begin
            $error("value expected %0d actual %0d", e.value, value_o);
            fails++;
          end
          if (status_o !== e.status) begin
            $error("status expected %0d actual %0d", e.status, status_o);
            fails++;
          end
        end
      end
      out_ready_i <= !hold_out && (no_idle || $urandom_range(99) >= 28);
    end
  end

  function automatic word_t mk(opcode_e op, int unsigned e, int unsigned t);
    word_t w;
    w.op = op;
    w.elem = ELEM_W'(e);
    w.team = TEAM_W'(t);
    return w;
  endfunction

  task automatic drain();
    while (pending_words.size() > 0 || in_valid_i || expected_replies.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    foreach (team_of[i]) team_of[i] = '0;
    clear_queues();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed corners
    add_word(mk(OP_DEQUEUE, 1023, 63));
    add_word(mk(OP_ASSIGN, 1023, 63));
    add_word(mk(OP_ASSIGN, 0, 0));
    add_word(mk(OP_ASSIGN, 5, 42));
    add_word(mk(OP_ENQUEUE, 1023, 0));
    add_word(mk(OP_ENQUEUE, 0, 63));
    add_word(mk(OP_ENQUEUE, 5, 0));
    add_word(mk(OP_ENQUEUE, 682, 21));
    add_word(mk(OP_ENQUEUE, 341, 42));
    add_word(mk(OP_ENQUEUE, 1023, 0));
    for (int i = 0; i < 7; i++) add_word(mk(OP_DEQUEUE, 341, 21));
    add_word(mk(OP_CLEAR, 1023, 63));
    add_word(mk(OP_ENQUEUE, 1023, 63));
    add_word(mk(OP_DEQUEUE, 0, 0));
    add_word(mk(OP_DEQUEUE, 0, 0));
    drain();

    // fill the node store and overflow it, receiver held off meanwhile
    no_idle = 1'b1;
    for (int i = 0; i < 24; i++) add_word(mk(OP_ASSIGN, i, $urandom_range(63)));
    for (int i = 0; i < CAP + 3; i++)
      add_word(mk(OP_ENQUEUE, $urandom_range(31), 0));
    for (int i = 0; i < 8; i++) add_word(mk(OP_DEQUEUE, 0, 0));
    fork
      begin
        hold_out = 1'b1;
        repeat (6000) @(posedge clk_i);
        hold_out = 1'b0;
      end
    join_none
    wait (hold_out);
    wait (!hold_out);
    add_word(mk(OP_CLEAR, 0, 0));
    drain();
    no_idle = 1'b0;

    // random team scenarios
    while (n_sent < 1150) begin
      int unsigned nt, base;
      nt = $urandom_range(1, 8);
      base = $urandom_range(0, 1000);
      for (int i = 0; i < 12; i++)
        add_word(mk(OP_ASSIGN, $urandom_range(base, base + 23),
                    $urandom_range(nt - 1, 0) * 7 % 64));
      for (int i = 0; i < 60; i++) begin
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55)
          add_word(mk(OP_ENQUEUE, $urandom_range(base, base + 23), $urandom_range(63)));
        else if (r < 95)
          add_word(mk(OP_DEQUEUE, $urandom_range(1023), $urandom_range(63)));
        else if (r < 98)
          add_word(mk(OP_ASSIGN, $urandom_range(1023), $urandom_range(63)));
        else
          add_word(mk(opcode_e'($urandom_range(3)), $urandom_range(1023),
                      $urandom_range(63)));
      end
      for (int i = 0; i < 4; i++) add_word(mk(OP_DEQUEUE, 0, 0));
      if ($urandom_range(3) == 0)
        add_word(mk(OP_CLEAR, $urandom_range(1023), $urandom_range(63)));
      drain();
    end
    repeat (100) @(posedge clk_i);

    $display("sent %0d words, including a full node store under a long output stall",
             n_sent);
    $display("checked %0d replies: %0d on empty, %0d dropped full", n_replies,
             n_empty, n_full);
    if (fails == 0 && expected_replies.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #40000000;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

endmodule
